// ===== design/hcf_pkg.sv =====
// Shared types, codes and helpers for the hex command frame handler.
// No dependencies.
package hcf_pkg;

   localparam logic [7:0] CHAR_START_IN  = 8'h3E;   // '>'
   localparam logic [7:0] CHAR_START_OUT = 8'h3C;   // '<'
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;

   localparam logic [7:0] CODE_SPEED = 8'h00;
   localparam logic [7:0] CODE_DUTY  = 8'h01;
   localparam logic [7:0] CODE_BAD   = 8'h02;

   // only the first four stored characters are ever decoded
   localparam int DECODE_CHARS = 4;
   localparam int DECODE_IDX_W = 2;

   // reply word index width, longest reply is 13 words
   localparam int REPLY_IDX_W = 4;

   typedef enum logic [1:0] {
      REPLY_SPEED,   // '<' 00 + 8 digits + CRLF
      REPLY_DUTY,    // '<' 01 + 2 digits + CRLF
      REPLY_SHORT    // '<' XX + CRLF
   } reply_kind_type;

   localparam logic [REPLY_IDX_W-1:0] LAST_SPEED = 4'd12;
   localparam logic [REPLY_IDX_W-1:0] LAST_DUTY  = 4'd6;
   localparam logic [REPLY_IDX_W-1:0] LAST_SHORT = 4'd4;

   typedef struct packed {
      reply_kind_type kind;
      logic [7:0]     code;
      logic [31:0]    payload;   // speed, or duty in the low byte
      logic [7:0]     duty;      // duty register after the closing byte
      logic           set_duty;
   } reply_desc_type;

   // 0..15 for a hex digit, 16 otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h41 + 8'd10)};
      else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h61 + 8'd10)};
      return v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
      else c = 8'h41 + {4'd0, nib} - 8'd10;
      return c;
   endfunction

   function automatic logic [REPLY_IDX_W-1:0] last_index(input reply_kind_type kind);
      logic [REPLY_IDX_W-1:0] l;
      unique case (kind)
         REPLY_SPEED: l = LAST_SPEED;
         REPLY_DUTY:  l = LAST_DUTY;
         default:     l = LAST_SHORT;
      endcase
      return l;
   endfunction

endpackage

// ===== design/hcf_parser.sv =====
// Frame parser: frame state, stored characters, duty register and command decode.
// Depends on hcf_pkg.
module hcf_parser import hcf_pkg::*; #(
   parameter int FRAME_CHARS = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_char,
   input  logic [31:0]    fan_speed,
   output logic           reply_load,
   output reply_desc_type reply_desc
);

   localparam int CountWidth = $clog2(FRAME_CHARS + 1);

   logic                  in_frame_ff, in_frame_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            duty_ff, duty_in;
   logic [7:0]            chars_ff [DECODE_CHARS];
   logic                  store;

   logic [4:0] h0, h1, h2, h3;
   logic       cmd_ok, duty_ok, is_term;
   logic [7:0] cmd_val, duty_val;

   assign h0 = hex_value(chars_ff[0]);
   assign h1 = hex_value(chars_ff[1]);
   assign h2 = hex_value(chars_ff[2]);
   assign h3 = hex_value(chars_ff[3]);

   assign cmd_val  = {h0[3:0], h1[3:0]};
   assign duty_val = {h2[3:0], h3[3:0]};
   assign cmd_ok   = (count_ff >= CountWidth'(2)) && !h0[4] && !h1[4];
   assign duty_ok  = (count_ff >= CountWidth'(4)) && !h2[4] && !h3[4];
   assign is_term  = (rx_char == CHAR_CR) || (rx_char == CHAR_LF);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      duty_in     = duty_ff;
      store       = 1'b0;
      reply_load  = 1'b0;
      if (accept) begin
         if (rx_char == CHAR_START_IN) begin
            in_frame_in = 1'b1;
            count_in    = '0;
         end else if (in_frame_ff) begin
            if (!is_term) begin
               if (count_ff >= CountWidth'(FRAME_CHARS)) begin
                  in_frame_in = 1'b0;   // overlong, drop silently
               end else begin
                  store    = (count_ff < CountWidth'(DECODE_CHARS));
                  count_in = count_ff + CountWidth'(1);
               end
            end else begin
               in_frame_in = 1'b0;
               reply_load  = 1'b1;
               if (cmd_ok && cmd_val == CODE_DUTY && duty_ok) duty_in = duty_val;
            end
         end
      end
   end

   always_comb begin
      reply_desc.duty     = duty_in;
      reply_desc.set_duty = 1'b0;
      reply_desc.payload  = fan_speed;
      reply_desc.code     = CODE_BAD;
      reply_desc.kind     = REPLY_SHORT;
      if (cmd_ok) begin
         if (cmd_val == CODE_SPEED) begin
            reply_desc.code = CODE_SPEED;
            reply_desc.kind = REPLY_SPEED;
         end else if (cmd_val == CODE_DUTY) begin
            if (duty_ok) begin
               reply_desc.code     = CODE_DUTY;
               reply_desc.kind     = REPLY_DUTY;
               reply_desc.set_duty = 1'b1;
               reply_desc.payload  = {24'd0, duty_val};
            end
         end else begin
            reply_desc.code = cmd_val;   // echo
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         duty_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         duty_ff     <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) chars_ff[count_ff[DECODE_IDX_W-1:0]] <= rx_char;
   end

endmodule

// ===== design/hcf_reply.sv =====
// Reply serializer: holds one reply descriptor, emits a word per rsp_ready cycle.
// Depends on hcf_pkg.
module hcf_reply import hcf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           reply_load,
   input  reply_desc_type reply_desc,
   output logic           busy,
   output logic           finishing,
   input  logic           rsp_ready,
   output logic [7:0]     tx_char,
   output logic           last_char,
   output logic           pwm_write,
   output logic [7:0]     pwm_duty
);

   logic                   busy_ff, busy_in;
   logic [REPLY_IDX_W-1:0] idx_ff, idx_in;
   reply_desc_type         desc_ff;
   logic [REPLY_IDX_W-1:0] last_idx, sel_full;
   logic [2:0]             sel;

   assign last_idx  = last_index(desc_ff.kind);
   assign last_char = (idx_ff == last_idx);
   assign busy      = busy_ff;
   assign finishing = busy_ff && last_char && rsp_ready;
   assign pwm_write = desc_ff.set_duty && (idx_ff == '0);
   assign pwm_duty  = desc_ff.duty;

   // payload digit, most significant first, ending two words before LF
   assign sel_full = last_idx - REPLY_IDX_W'(2) - idx_ff;
   assign sel      = sel_full[2:0];

   always_comb begin
      if (idx_ff == last_idx) tx_char = CHAR_LF;
      else if (idx_ff == last_idx - REPLY_IDX_W'(1)) tx_char = CHAR_CR;
      else if (idx_ff == REPLY_IDX_W'(0)) tx_char = CHAR_START_OUT;
      else if (idx_ff == REPLY_IDX_W'(1)) tx_char = hex_char(desc_ff.code[7:4]);
      else if (idx_ff == REPLY_IDX_W'(2)) tx_char = hex_char(desc_ff.code[3:0]);
      else tx_char = hex_char(desc_ff.payload[{sel, 2'b00} +: 4]);
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff && rsp_ready) begin
         if (last_char) busy_in = 1'b0;
         idx_in = idx_ff + REPLY_IDX_W'(1);
      end
      if (reply_load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_load) desc_ff <= reply_desc;
   end

endmodule

// ===== design/hex_command_frame_handler.sv =====
// Hex command frame handler for a fan controller serial link.
// Depends on hcf_pkg, hcf_parser, hcf_reply.
// Usage:
//   req_ channel: one received ASCII word per handshake, with the current fan
//   speed sample alongside. '>' opens a frame, CR or LF closes it.
//   rsp_ channel: reply words, '<' + hex fields + CRLF; rsp_last_char marks
//   the LF, rsp_pwm_write flags the first word of an accepted duty set, and
//   rsp_pwm_duty carries the applied duty.
// Timing:
//   Data words are taken one per cycle outside a reply; they only update
//   frame state. A closing word is decoded in the cycle it is accepted;
//   the first reply word is valid on the next cycle and the rest follow
//   one per cycle unless stalled (13 words for a speed read, 7 for a duty
//   set, 5 otherwise). req_ready is low while a reply is in flight; it
//   rises again in the cycle the LF is taken, so the next word can overlap
//   that handshake. A data word never lowers req_ready; a closing word
//   holds it low until the LF of its reply is taken.
// Reset: synchronous, closes any open frame, clears the duty to zero and
//   drops any pending reply. A stalled receiver simply holds the current
//   reply word and blocks further input.
module hex_command_frame_handler import hcf_pkg::*; #(
   parameter int FRAME_CHARS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_char,
   input  logic [31:0] req_fan_speed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_char,
   output logic        rsp_last_char,
   output logic        rsp_pwm_write,
   output logic [7:0]  rsp_pwm_duty
);

   logic           accept;
   logic           reply_load;
   reply_desc_type reply_desc;
   logic           busy, finishing;

   // input is blocked only while a reply is still being sent
   assign req_ready = !busy || finishing;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = busy;

   hcf_parser #(
      .FRAME_CHARS(FRAME_CHARS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_char    (req_rx_char),
      .fan_speed  (req_fan_speed),
      .reply_load (reply_load),
      .reply_desc (reply_desc)
   );

   hcf_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .reply_load (reply_load),
      .reply_desc (reply_desc),
      .busy       (busy),
      .finishing  (finishing),
      .rsp_ready  (rsp_ready),
      .tx_char    (rsp_tx_char),
      .last_char  (rsp_last_char),
      .pwm_write  (rsp_pwm_write),
      .pwm_duty   (rsp_pwm_duty)
   );

endmodule

// ===== design/hcf_checker.sv =====
// Port-level checks for the hex command frame handler, bound to the top level.
// Depends on hcf_pkg and hex_command_frame_handler.
module hcf_checker import hcf_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_char,
   input logic       rsp_last_char,
   input logic       rsp_pwm_write
);

   // stalled reply word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_char))
      else $error("reply word changed under stall");

   a_last_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_tx_char == CHAR_LF)
      else $error("last word is not LF");

   a_pwm_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pwm_write |-> rsp_tx_char == CHAR_START_OUT)
      else $error("pwm strobe not on reply start");

   // reply words are contiguous once started
   a_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_char |=> rsp_valid)
      else $error("gap inside reply");

   // no input taken mid-reply
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_ready && rsp_last_char) |-> !req_ready)
      else $error("input accepted during reply");

endmodule

bind hex_command_frame_handler hcf_checker u_hcf_checker (.*);
